// ===== rtl/plfd_pkg.sv =====
package plfd_pkg;

    // Size of the receive buffer the flush limit is capped against
    localparam int unsigned BufferBytes = 512;
    // Depth of the result word queue
    localparam int unsigned QueueDepth  = 4;

    // Frame layout
    localparam logic [8:0] LenBytePos   = 9'd3;
    localparam logic [8:0] TrailerBytes = 9'd2;
    localparam logic [3:0] MinHeader    = 4'd4;
    localparam logic [8:0] LockPos      = 9'd2;

    // Configuration reset values
    localparam logic [15:0] RstMsgPre   = 16'd0;
    localparam logic [15:0] RstCtlPre   = 16'd0;
    localparam logic [3:0]  RstHdrLen   = 4'd4;
    localparam logic [8:0]  RstFlushThr = 9'd256;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MSG_PRE   = 2'd0,
        REG_CTL_PRE   = 2'd1,
        REG_HDR_LEN   = 2'd2,
        REG_FLUSH_THR = 2'd3
    } t_reg_idx;

    // Frame kind codes
    localparam logic KindMsg = 1'b0;
    localparam logic KindCtl = 1'b1;

    // One output word
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       kind;
    } t_word;

    // Words produced by one input byte, w0 goes out first
    typedef struct packed {
        logic [1:0] num;
        t_word      w0;
        t_word      w1;
    } t_push;

endpackage

// ===== rtl/plfd_core.sv =====
module plfd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    output plfd_pkg::t_push       o_push
);

    // Flush limit never exceeds the buffer size minus one
    localparam int unsigned LimitCap =
        (plfd_pkg::BufferBytes - 1 > 511) ? 511 : plfd_pkg::BufferBytes - 1;
    localparam logic [8:0] LimitCapV = 9'(LimitCap);

    // Configuration registers
    logic [15:0] r_msg_pre;
    logic [15:0] r_ctl_pre;
    logic [3:0]  r_hdr_len;
    logic [8:0]  r_flush_thr;

    // Deframer state
    logic [7:0] r_held,       n_held;
    logic       r_held_valid, n_held_valid;
    logic [8:0] r_hunt,       n_hunt;
    logic       r_locked,     n_locked;
    logic [8:0] r_pos,        n_pos;
    logic [8:0] r_exp,        n_exp;
    logic       r_kind,       n_kind;

    logic [3:0]  hdr_len;
    logic [15:0] pair;
    logic        is_msg;
    logic        is_ctl;
    logic [8:0]  limit;
    logic [8:0]  hunt_inc;
    logic [8:0]  pos_inc;
    logic [8:0]  exp_len;
    logic        last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_pre   <= plfd_pkg::RstMsgPre;
            r_ctl_pre   <= plfd_pkg::RstCtlPre;
            r_hdr_len   <= plfd_pkg::RstHdrLen;
            r_flush_thr <= plfd_pkg::RstFlushThr;
        end else if (i_cfg_we) begin
            case (plfd_pkg::t_reg_idx'(i_cfg_index))
                plfd_pkg::REG_MSG_PRE:   r_msg_pre   <= i_cfg_data;
                plfd_pkg::REG_CTL_PRE:   r_ctl_pre   <= i_cfg_data;
                plfd_pkg::REG_HDR_LEN:   r_hdr_len   <= i_cfg_data[3:0];
                plfd_pkg::REG_FLUSH_THR: r_flush_thr <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Shared terms
    assign hdr_len  = (r_hdr_len < plfd_pkg::MinHeader) ? plfd_pkg::MinHeader : r_hdr_len;
    assign pair     = {i_byte, r_held};
    assign is_msg   = (pair == r_msg_pre);
    assign is_ctl   = (pair == r_ctl_pre);
    assign limit    = (r_flush_thr > LimitCapV) ? LimitCapV : r_flush_thr;
    assign hunt_inc = r_hunt + 9'd1;
    assign pos_inc  = r_pos + 9'd1;
    assign exp_len  = 9'(hdr_len) + 9'(i_byte) + plfd_pkg::TrailerBytes;

    // Next state and produced words
    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_hunt       = r_hunt;
        n_locked     = r_locked;
        n_pos        = r_pos;
        n_exp        = r_exp;
        n_kind       = r_kind;
        last         = 1'b0;
        o_push       = '0;

        if (i_accept) begin
            if (!r_locked) begin
                if (r_held_valid && (is_msg || is_ctl)) begin
                    // Sync word found: emit both preamble bytes
                    n_kind       = is_msg ? plfd_pkg::KindMsg : plfd_pkg::KindCtl;
                    n_locked     = 1'b1;
                    n_pos        = plfd_pkg::LockPos;
                    n_exp        = '0;
                    n_held_valid = 1'b0;
                    n_hunt       = '0;
                    o_push.num   = 2'd2;
                    o_push.w0    = '{data: r_held, first: 1'b1, last: 1'b0, kind: n_kind};
                    o_push.w1    = '{data: i_byte, first: 1'b0, last: 1'b0, kind: n_kind};
                end else if (hunt_inc >= limit) begin
                    // Flush everything held so far
                    n_hunt       = '0;
                    n_held_valid = 1'b0;
                    n_held       = '0;
                end else begin
                    n_hunt       = hunt_inc;
                    n_held       = i_byte;
                    n_held_valid = 1'b1;
                end
            end else begin
                // Forward frame byte, length byte sets the frame end
                if (r_pos == plfd_pkg::LenBytePos) begin
                    n_exp = exp_len;
                end
                n_pos = pos_inc;
                if (n_exp != '0 && n_pos >= n_exp) begin
                    last         = 1'b1;
                    n_locked     = 1'b0;
                    n_pos        = '0;
                    n_exp        = '0;
                    n_hunt       = '0;
                    n_held_valid = 1'b0;
                    n_held       = '0;
                end
                o_push.num = 2'd1;
                o_push.w0  = '{data: i_byte, first: 1'b0, last: last, kind: r_kind};
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_hunt       <= '0;
            r_locked     <= 1'b0;
            r_pos        <= '0;
            r_exp        <= '0;
            r_kind       <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_hunt       <= n_hunt;
            r_locked     <= n_locked;
            r_pos        <= n_pos;
            r_exp        <= n_exp;
            r_kind       <= n_kind;
        end
    end

    // A preamble pair always leaves the block locked
    a_pair_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num == 2'd2) |=> r_locked)
        else $error("preamble pair did not lock");

    // Nothing is held while a frame is being forwarded
    a_locked_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked |-> !r_held_valid)
        else $error("held byte valid while locked");

    // A known frame end exists only inside a frame
    a_exp_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != '0) |-> (r_locked && r_pos > plfd_pkg::LenBytePos))
        else $error("frame end set outside a frame");

endmodule

// ===== rtl/plfd_oq.sv =====
module plfd_oq #(
    parameter int unsigned DEPTH = plfd_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plfd_pkg::t_push   i_push,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output plfd_pkg::t_word   o_word
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullAt   = CW'(DEPTH - 1);

    plfd_pkg::t_word r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   wr_next;
    logic            pop;

    assign wr_next = (r_wr == LastAddr) ? '0 : r_wr + AW'(1);
    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd];
    // Room is kept for a full preamble pair
    assign o_full  = (r_count >= FullAt);

    // Pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count + CW'(i_push.num);
        if (i_push.num == 2'd1) begin
            n_wr = wr_next;
        end else if (i_push.num == 2'd2) begin
            n_wr = (wr_next == LastAddr) ? '0 : wr_next + AW'(1);
        end
        if (pop) begin
            n_rd    = (r_rd == LastAddr) ? '0 : r_rd + AW'(1);
            n_count = n_count - CW'(1);
        end
    end

    // Word storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Fill level stays within the storage
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("output queue overflow");

    // Words only arrive while there is room for a pair
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> (r_count <= CW'(DEPTH - 2)))
        else $error("push into a queue without room");

    // A pair push grows the level by at least one
    a_pair_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num == 2'd2) |=> (r_count >= CW'(1) && r_count == $past(r_count) + CW'(2)
            - CW'($past(pop))))
        else $error("pair push lost a word");

endmodule

// ===== rtl/preamble_length_deframer_top.sv =====
// Channel   Direction  Handshake                 Word
// -------   ---------  ------------------------  ----------------------------------------
// in        sink       i_in_valid / o_in_stall   i_in_byte
// out       source     o_out_valid / i_out_stall o_out_byte, o_first_byte, o_last,
//                                                o_frame_kind
// cfg       sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One input byte can be taken every cycle while o_in_stall is low; its words are written
// into the output queue at the accepting edge and are offered from there in order.
// A matched preamble yields two words, so a sustained stream of pairs drains at one word
// per cycle while i_out_stall is low; o_in_stall rises when under two slots are free.
// o_in_stall depends only on the queue fill level, never on i_out_stall in the same cycle.
// Synchronous active-low reset clears the queue and returns the block to hunting.
module preamble_length_deframer_top #(
    parameter int unsigned QUEUE_DEPTH = plfd_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_first_byte,
    output logic        o_last,
    output logic        o_frame_kind
);

    plfd_pkg::t_push push;
    plfd_pkg::t_word word;
    logic            accept;
    logic            full;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // Hunting, lock and frame tracking
    plfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .o_push      (push)
    );

    // Output words wait here until taken
    plfd_oq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (word)
    );

    assign o_out_byte   = word.data;
    assign o_first_byte = word.first;
    assign o_last       = word.last;
    assign o_frame_kind = word.kind;

endmodule
